[rtl/core/csbc_pkg.sv]
// Shared types, character codes, operator codes and status codes of the line calculator.
package csbc_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_AND = 4'd4;
    localparam logic [3:0] OP_OR  = 4'd5;
    localparam logic [3:0] OP_XOR = 4'd6;
    localparam logic [3:0] OP_LSR = 4'd7;
    localparam logic [3:0] OP_SHL = 4'd8;
    localparam logic [3:0] OP_ASR = 4'd9;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OPCOUNT = 2'd1;
    localparam logic [1:0] STAT_BADCHAR = 2'd2;
    localparam logic [1:0] STAT_DIVZERO = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } op_hit_t;

    // Start request for the iterative multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    function automatic op_hit_t op_lookup(input logic [7:0] c);
        op_hit_t r;
        r.hit  = 1'b1;
        r.code = OP_ADD;
        case (c)
            CH_PLUS:   r.code = OP_ADD;
            CH_MINUS:  r.code = OP_SUB;
            CH_STAR:   r.code = OP_MUL;
            CH_SLASH:  r.code = OP_DIV;
            CH_AMP:    r.code = OP_AND;
            CH_BAR:    r.code = OP_OR;
            CH_CARET:  r.code = OP_XOR;
            CH_GT:     r.code = OP_LSR;
            CH_LT:     r.code = OP_SHL;
            CH_RBRACE: r.code = OP_ASR;
            default:   r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/csbc_muldiv.sv]
// Iterative shift-add multiplier and restoring signed divider sharing one adder.
module csbc_muldiv #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  csbc_pkg::md_req_t        req,
    input  logic [OPERAND_WIDTH-1:0] op_a,
    input  logic [OPERAND_WIDTH-1:0] op_b,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] result
);
    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    logic [W:0]    acc_reg;   // product, or partial remainder
    logic [W-1:0]  x_reg;     // multiplicand, or dividend shifting into quotient
    logic [W-1:0]  y_reg;     // multiplier, or divisor
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          div_reg;
    logic          neg_reg;

    logic [W:0]   rem_shift;
    logic [W+1:0] add_x;
    logic [W+1:0] add_y;
    logic [W+1:0] add_sum;
    logic         fits;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;

    always_comb begin
        rem_shift = {acc_reg[W-1:0], x_reg[W-1]};
        if (div_reg) begin
            add_x = {1'b0, rem_shift};
            add_y = ~{2'b00, y_reg};
        end else begin
            add_x = {2'b00, acc_reg[W-1:0]};
            add_y = y_reg[0] ? {2'b00, x_reg} : '0;
        end
        add_sum = add_x + add_y + {{(W+1){1'b0}}, div_reg};
        // A clear top bit means the shifted remainder is at least the divisor.
        fits  = ~add_sum[W+1];
        mag_a = op_a[W-1] ? W'(-op_a) : op_a;
        mag_b = op_b[W-1] ? W'(-op_b) : op_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            div_reg <= req.is_div;
            neg_reg <= op_a[W-1] ^ op_b[W-1];
            acc_reg <= '0;
            x_reg   <= req.is_div ? mag_a : op_a;
            y_reg   <= req.is_div ? mag_b : op_b;
        end else if (busy_reg) begin
            if (div_reg) begin
                acc_reg <= fits ? add_sum[W:0] : rem_shift;
                x_reg   <= {x_reg[W-2:0], fits};
            end else begin
                acc_reg <= {1'b0, add_sum[W-1:0]};
                x_reg   <= {x_reg[W-2:0], 1'b0};
                y_reg   <= {1'b0, y_reg[W-1:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? W'(-x_reg) : x_reg) : acc_reg[W-1:0];

endmodule

[rtl/core/char_stream_binary_calculator.sv]
// Top level of the character-stream calculator: line parser, sequencer and output register.
//
// Character words are taken while the sequencer is idle and fold into the operand
// accumulators; a word with tlast set ends the line and is evaluated. Add,
// subtract, logic operations, shifts and every error case go from the end-of-line
// word straight to the DONE state and from there into the output register.
// Multiply and divide run in a shared adder one bit per cycle in the RUN state
// before DONE; s_tready is low from the end-of-line word until its result is in
// the output register, while a finished result waiting on m_tready does not stop
// the next line's characters.
module char_stream_binary_calculator #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] ch
    input  logic         s_tlast,   // end_of_line
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] status, [5:2] op_code, [37:6] operand_a, [69:38] operand_b,
    // [101:70] result, [103:102] zero
    output logic [103:0] m_tdata
);
    localparam int W    = OPERAND_WIDTH;
    localparam int SH_W = $clog2(W);
    localparam logic [W-1:0] WIDTH_VAL = W'(W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]   state_reg;
    logic [1:0]   op_count_reg;
    logic [3:0]   op_code_reg;
    logic         seen_op_reg;
    logic [W-1:0] left_reg;
    logic [W-1:0] right_reg;
    logic         bad_reg;
    logic [1:0]   status_reg;
    logic [W-1:0] res_reg;

    logic         m_valid_reg;
    logic [1:0]   out_status_reg;
    logic [3:0]   out_op_reg;
    logic [31:0]  out_a_reg;
    logic [31:0]  out_b_reg;
    logic [31:0]  out_res_reg;

    csbc_pkg::op_hit_t op_hit;
    csbc_pkg::md_req_t md_req;
    logic         accept;
    logic         char_acc;
    logic         eol_acc;
    logic         is_digit;
    logic [3:0]   digit;
    logic [W-1:0] acc_src;
    logic [W-1:0] acc_mac;
    logic [1:0]   status_now;
    logic         need_md;
    logic [W-1:0] alu_res;
    logic         shift_big;
    logic [SH_W-1:0] shamt;
    logic         out_free;
    logic         md_done;
    logic [W-1:0] md_result;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign char_acc = accept && !s_tlast;
    assign eol_acc  = accept && s_tlast;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        op_hit   = csbc_pkg::op_lookup(s_tdata);
        is_digit = (s_tdata >= csbc_pkg::CH_ZERO) && (s_tdata <= csbc_pkg::CH_NINE);
        digit    = 4'(s_tdata - csbc_pkg::CH_ZERO);
        acc_src  = seen_op_reg ? right_reg : left_reg;
        // Times ten as eight plus two, then the new digit.
        acc_mac  = (acc_src << 3) + (acc_src << 1) + W'(digit);

        if (op_count_reg != 2'd1) begin
            status_now = csbc_pkg::STAT_OPCOUNT;
        end else if (bad_reg) begin
            status_now = csbc_pkg::STAT_BADCHAR;
        end else if (op_code_reg == csbc_pkg::OP_DIV && right_reg == '0) begin
            status_now = csbc_pkg::STAT_DIVZERO;
        end else begin
            status_now = csbc_pkg::STAT_OK;
        end
        need_md = (status_now == csbc_pkg::STAT_OK) &&
                  (op_code_reg == csbc_pkg::OP_MUL || op_code_reg == csbc_pkg::OP_DIV);

        shift_big = (right_reg >= WIDTH_VAL);
        shamt     = right_reg[SH_W-1:0];
        case (op_code_reg)
            csbc_pkg::OP_ADD: alu_res = left_reg + right_reg;
            csbc_pkg::OP_SUB: alu_res = left_reg - right_reg;
            csbc_pkg::OP_AND: alu_res = left_reg & right_reg;
            csbc_pkg::OP_OR:  alu_res = left_reg | right_reg;
            csbc_pkg::OP_XOR: alu_res = left_reg ^ right_reg;
            csbc_pkg::OP_LSR: alu_res = shift_big ? '0 : (left_reg >> shamt);
            csbc_pkg::OP_SHL: alu_res = shift_big ? '0 : (left_reg << shamt);
            csbc_pkg::OP_ASR: alu_res = shift_big ? {W{left_reg[W-1]}}
                                                  : W'($signed(left_reg) >>> shamt);
            default:          alu_res = '0;
        endcase

        md_req.start  = eol_acc && need_md;
        md_req.is_div = (op_code_reg == csbc_pkg::OP_DIV);
    end

    csbc_muldiv #(
        .OPERAND_WIDTH(W)
    ) u_muldiv (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (md_req),
        .op_a   (left_reg),
        .op_b   (right_reg),
        .done   (md_done),
        .result (md_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            op_count_reg <= '0;
            op_code_reg  <= '0;
            seen_op_reg  <= 1'b0;
            left_reg     <= '0;
            right_reg    <= '0;
            bad_reg      <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (eol_acc) begin
                        state_reg <= need_md ? ST_RUN : ST_DONE;
                    end else if (char_acc) begin
                        if (op_hit.hit) begin
                            if (op_count_reg != 2'd2) begin
                                op_count_reg <= op_count_reg + 2'd1;
                            end
                            op_code_reg <= op_hit.code;
                            seen_op_reg <= 1'b1;
                        end else if (is_digit) begin
                            if (seen_op_reg) begin
                                right_reg <= acc_mac;
                            end else begin
                                left_reg <= acc_mac;
                            end
                        end else begin
                            bad_reg <= 1'b1;
                        end
                    end
                end
                ST_RUN: begin
                    if (md_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg    <= ST_IDLE;
                        m_valid_reg  <= 1'b1;
                        op_count_reg <= '0;
                        op_code_reg  <= '0;
                        seen_op_reg  <= 1'b0;
                        left_reg     <= '0;
                        right_reg    <= '0;
                        bad_reg      <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (eol_acc) begin
            status_reg <= status_now;
            res_reg    <= alu_res;
        end else if (md_done) begin
            res_reg <= md_result;
        end
        if (state_reg == ST_DONE && out_free) begin
            out_status_reg <= status_reg;
            out_op_reg     <= op_code_reg;
            out_a_reg      <= 32'($signed(left_reg));
            out_b_reg      <= 32'($signed(right_reg));
            out_res_reg    <= (status_reg == csbc_pkg::STAT_OK) ? 32'($signed(res_reg)) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg, out_b_reg, out_a_reg, out_op_reg, out_status_reg};

    a_load_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished result was not loaded into the output register");

    a_error_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != csbc_pkg::STAT_OK) |-> (m_tdata[101:70] == 32'd0))
        else $error("nonzero result word carries an error status");

    a_md_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> (state_reg == ST_RUN))
        else $error("multiply/divide finished outside its run state");

    a_eol_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        eol_acc |=> (state_reg != ST_IDLE && !s_tready))
        else $error("end-of-line word did not start an evaluation");

endmodule

[test/tb_char_stream_binary_calculator.sv]
// Self-checking testbench for the character-stream line calculator with its own line evaluator.
`timescale 1ns / 100ps

module tb_char_stream_binary_calculator;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_WORDS   = 260;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
    } calc_answer_t;

    // Tracks the line being typed and holds the answers still owed by the block.
    class line_scoreboard;
        calc_answer_t answers_due[$];
        int           errors     = 0;
        logic [1:0]   op_count   = '0;
        logic [3:0]   op_code    = csbc_pkg::OP_ADD;
        bit           seen_op    = 0;
        logic [31:0]  left_acc   = '0;
        logic [31:0]  right_acc  = '0;
        bit           bad_char   = 0;

        function void absorb_char(logic [7:0] ch, logic eol);
            calc_answer_t ans;
            logic [3:0]   code;
            bit           is_op;
            if (!eol) begin
                is_op = 1;
                code  = csbc_pkg::OP_ADD;
                case (ch)
                    csbc_pkg::CH_PLUS:   code = csbc_pkg::OP_ADD;
                    csbc_pkg::CH_MINUS:  code = csbc_pkg::OP_SUB;
                    csbc_pkg::CH_STAR:   code = csbc_pkg::OP_MUL;
                    csbc_pkg::CH_SLASH:  code = csbc_pkg::OP_DIV;
                    csbc_pkg::CH_AMP:    code = csbc_pkg::OP_AND;
                    csbc_pkg::CH_BAR:    code = csbc_pkg::OP_OR;
                    csbc_pkg::CH_CARET:  code = csbc_pkg::OP_XOR;
                    csbc_pkg::CH_GT:     code = csbc_pkg::OP_LSR;
                    csbc_pkg::CH_LT:     code = csbc_pkg::OP_SHL;
                    csbc_pkg::CH_RBRACE: code = csbc_pkg::OP_ASR;
                    default:             is_op = 0;
                endcase
                if (is_op) begin
                    if (op_count < 2'd2) op_count = op_count + 2'd1;
                    op_code = code;
                    seen_op = 1;
                end else if (ch >= csbc_pkg::CH_ZERO && ch <= csbc_pkg::CH_NINE) begin
                    if (seen_op) right_acc = right_acc * 10 + (ch - csbc_pkg::CH_ZERO);
                    else         left_acc  = left_acc * 10 + (ch - csbc_pkg::CH_ZERO);
                end else begin
                    bad_char = 1;
                end
                return;
            end

            ans.op  = op_code;
            ans.a   = left_acc;
            ans.b   = right_acc;
            ans.res = '0;
            if (op_count != 2'd1)
                ans.status = csbc_pkg::STAT_OPCOUNT;
            else if (bad_char)
                ans.status = csbc_pkg::STAT_BADCHAR;
            else if (op_code == csbc_pkg::OP_DIV && right_acc == 0)
                ans.status = csbc_pkg::STAT_DIVZERO;
            else
                ans.status = csbc_pkg::STAT_OK;

            if (ans.status == csbc_pkg::STAT_OK) begin
                case (op_code)
                    csbc_pkg::OP_ADD: ans.res = left_acc + right_acc;
                    csbc_pkg::OP_SUB: ans.res = left_acc - right_acc;
                    csbc_pkg::OP_MUL: ans.res = left_acc * right_acc;
                    csbc_pkg::OP_DIV: begin
                        // The most negative value divided by minus one wraps around.
                        if (left_acc == 32'h8000_0000 && right_acc == 32'hFFFF_FFFF)
                            ans.res = 32'h8000_0000;
                        else
                            ans.res = $signed(left_acc) / $signed(right_acc);
                    end
                    csbc_pkg::OP_AND: ans.res = left_acc & right_acc;
                    csbc_pkg::OP_OR:  ans.res = left_acc | right_acc;
                    csbc_pkg::OP_XOR: ans.res = left_acc ^ right_acc;
                    csbc_pkg::OP_LSR: begin
                        if (right_acc >= 32) ans.res = '0;
                        else                 ans.res = left_acc >> right_acc[4:0];
                    end
                    csbc_pkg::OP_SHL: begin
                        if (right_acc >= 32) ans.res = '0;
                        else                 ans.res = left_acc << right_acc[4:0];
                    end
                    csbc_pkg::OP_ASR: begin
                        if (right_acc >= 32) ans.res = {32{left_acc[31]}};
                        else                 ans.res = $signed(left_acc) >>> right_acc[4:0];
                    end
                    default: ans.res = '0;
                endcase
            end
            answers_due.push_back(ans);

            op_count  = '0;
            op_code   = csbc_pkg::OP_ADD;
            seen_op   = 0;
            left_acc  = '0;
            right_acc = '0;
            bad_char  = 0;
        endfunction

        function void check_answer(logic [103:0] data);
            calc_answer_t got;
            calc_answer_t want;
            got.status = data[1:0];
            got.op     = data[5:2];
            got.a      = data[37:6];
            got.b      = data[69:38];
            got.res    = data[101:70];
            if (answers_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: status %0d op %0d a %0d b %0d result %0d",
                             got.status, got.op, $signed(got.a), $signed(got.b),
                             $signed(got.res));
                return;
            end
            want = answers_due.pop_front();
            if (got.status !== want.status || got.op !== want.op || got.a !== want.a ||
                got.b !== want.b || got.res !== want.res) begin
                errors++;
                if (errors <= 10) begin
                    $display("result mismatch: expected status %0d op %0d a %0d b %0d result %0d",
                             want.status, want.op, $signed(want.a), $signed(want.b),
                             $signed(want.res));
                    $display("                 actual   status %0d op %0d a %0d b %0d result %0d",
                             got.status, got.op, $signed(got.a), $signed(got.b),
                             $signed(got.res));
                end
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;    // [7:0] ch
    logic         s_tlast  = 1'b0;  // end_of_line
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [1:0] status, [5:2] op_code, [37:6] operand_a, [69:38] operand_b,
    // [101:70] result, [103:102] zero
    logic [103:0] m_tdata;

    line_scoreboard sb;
    int           quiet_cycles = 0;
    int           words_sent   = 0;
    int           burst_left   = 0;
    logic [15:0]  rx_count     = '0;
    logic [1:0]   rx_mode      = '0;
    logic [7:0]   op_chars[10] = '{csbc_pkg::CH_PLUS, csbc_pkg::CH_MINUS, csbc_pkg::CH_STAR,
                                   csbc_pkg::CH_SLASH, csbc_pkg::CH_AMP, csbc_pkg::CH_BAR,
                                   csbc_pkg::CH_CARET, csbc_pkg::CH_GT, csbc_pkg::CH_LT,
                                   csbc_pkg::CH_RBRACE};

    char_stream_binary_calculator #(.OPERAND_WIDTH(32)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver picks a new stall pattern whenever the low byte of rx_count is zero.
    always @(posedge aclk) begin
        rx_count <= rx_count + 16'd1;
        if (rx_count[7:0] == 8'd0) rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= (rx_count[3:0] < 4'd3);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.absorb_char(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_answer(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else                                                  quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] ch, input logic eol);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                s_tlast  <= 1'($urandom);
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    // The end-of-line word carries a random character, which the block must ignore.
    task automatic send_text(input string s);
        foreach (s[i]) send_word(s[i], 1'b0);
        send_word(8'($urandom), 1'b1);
    endtask

    function automatic string random_operand();
        string s;
        int    n;
        s = "";
        case ($urandom_range(0, 5))
            0: s = "";
            1: s = $sformatf("%0d", $urandom_range(0, 99));
            2: s = $sformatf("%0d", $urandom);
            3: begin
                n = $urandom_range(11, 14);
                repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
            end
            4: s = ($urandom_range(0, 1) == 0) ? "2147483648" : "4294967295";
            default: s = $sformatf("%0d", $urandom_range(0, 9999));
        endcase
        return s;
    endfunction

    task automatic send_random_line();
        string      s;
        string      b_text;
        logic [7:0] op;
        logic [7:0] junk;
        int         k;
        int         n;
        k = $urandom_range(0, 9);
        op = op_chars[k];
        if (op == csbc_pkg::CH_GT || op == csbc_pkg::CH_LT || op == csbc_pkg::CH_RBRACE) begin
            if ($urandom_range(0, 9) < 7) b_text = $sformatf("%0d", $urandom_range(0, 40));
            else                          b_text = random_operand();
        end else if (op == csbc_pkg::CH_SLASH && $urandom_range(0, 4) == 0) begin
            b_text = "0";
        end else begin
            b_text = random_operand();
        end
        s = $sformatf("%s%c%s", random_operand(), op, b_text);

        case ($urandom_range(0, 19))
            0, 1: begin
                // A second operator somewhere after the first.
                s = $sformatf("%s%c%0d", s, op_chars[$urandom_range(0, 9)],
                              $urandom_range(0, 999));
            end
            2, 3: begin
                if ($urandom_range(0, 1) == 0) junk = 8'($urandom_range(8'h41, 8'h5A));
                else                           junk = 8'($urandom_range(8'h80, 8'hFF));
                k = $urandom_range(0, s.len());
                s = $sformatf("%s%c%s", s.substr(0, k - 1), junk, s.substr(k, s.len() - 1));
            end
            4, 5: begin
                // Raw noise, including characters that a string cannot hold.
                n = $urandom_range(0, 12);
                repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
                send_word(8'($urandom), 1'b1);
                return;
            end
            default: ;
        endcase
        send_text(s);
    endtask

    initial begin
        int start_count;
        sb = new;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("");
        send_text("12+34");
        send_text("5-9");
        send_text("65536*65537");
        send_text("2147483648/4294967295");
        send_text("7/0");
        send_text("12&10");
        send_text("12|10");
        send_text("12^10");
        send_text("2147483648>31");
        send_text("1<32");
        send_text("2147483648}40");
        send_text("2147483648}4");
        send_text("1+2-3");
        send_text("1a+2");
        send_text("99999999999+0");
        send_text("+");

        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS) send_random_line();
        s_tvalid <= 1'b0;

        while (sb.answers_due.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
